/* rtl/chained_ring_pointer_manager_macros.svh */
// Assertion macros for the chained ring pointer manager
`ifndef CHAINED_RING_POINTER_MANAGER_MACROS_SVH
`define CHAINED_RING_POINTER_MANAGER_MACROS_SVH

// property must hold at every edge outside reset
`define CRPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define CRPM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* rtl/crpm_pkg.sv */
// Types and constants shared by the chained ring pointer manager
package crpm_pkg;

  localparam int unsigned RingDepth = 1024;
  localparam int unsigned MaxStages = 8;
  localparam int unsigned IdxW      = $clog2(RingDepth);
  localparam int unsigned IdW       = $clog2(MaxStages);
  localparam int unsigned StepW     = IdxW + 1;
  localparam int unsigned CfgW      = 4;
  localparam int unsigned StatW     = 3;

  typedef logic [IdxW-1:0] idx_t;
  typedef idx_t [MaxStages-1:0] ptr_vec_t;

  typedef enum logic [1:0] {
    CmdReserve = 2'd0,
    CmdPeek    = 2'd1,
    CmdAdvance = 2'd2
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    StOk       = 3'd0,
    StFull     = 3'd1,
    StEmpty    = 3'd2,
    StBeyond   = 3'd3,
    StBadStage = 3'd4
  } status_e;

  typedef struct packed {
    logic             valid;
    logic [1:0]       cmd;
    logic [IdW-1:0]   id;
    logic [StepW-1:0] steps;
  } req_t;

  typedef struct packed {
    logic           tail_we;
    idx_t           tail_val;
    logic           ptr_we;
    logic [IdW-1:0] ptr_sel;
    idx_t           ptr_val;
  } ptr_upd_t;

  typedef struct packed {
    status_e status;
    idx_t    position;
    idx_t    avail;
  } rsp_t;

endpackage

/* rtl/chained_ring_pointer_manager.sv */
// Chained ring pointer manager top level: config, request and result registers
// A request is held in the request register, and its result in the result register.
// Throughput: one request per cycle; busy_o stays low, nothing stalls.
// Each request's pointer update lands with its result, so the next one sees it.
// Reset: tail, all stage pointers clear to zero, stage count becomes one.
// Results are shown for one cycle only; the receiver cannot hold them off.
`include "chained_ring_pointer_manager_macros.svh"
module chained_ring_pointer_manager import crpm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CfgW-1:0]  cfg_wdata_i,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [1:0]       cmd_i,
  input  logic [IdW-1:0]   module_id_i,
  input  logic [StepW-1:0] step_count_i,
  output logic             done_o,
  output logic [StatW-1:0] status_o,
  output logic [IdxW-1:0]  position_o,
  output logic [IdxW-1:0]  available_count_o
);

  logic [CfgW-1:0] n_eff_q;
  logic [CfgW-1:0] n_eff_d;
  logic accept;
  req_t req;
  ptr_upd_t upd;
  rsp_t rsp;
  rsp_t rsp_q;
  logic done_q;
  idx_t tail;
  ptr_vec_t ptrs;
  ptr_vec_t avails;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // stage count kept already clamped to 1..MaxStages
  always_comb begin
    if (cfg_wdata_i == '0) begin
      n_eff_d = CfgW'(1);
    end else if (cfg_wdata_i > CfgW'(MaxStages)) begin
      n_eff_d = CfgW'(MaxStages);
    end else begin
      n_eff_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_eff_q <= CfgW'(1);
    end else if (cfg_we_i) begin
      n_eff_q <= n_eff_d;
    end
  end

  crpm_req_reg u_req_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .cmd_i   (cmd_i),
    .id_i    (module_id_i),
    .steps_i (step_count_i),
    .req_o   (req)
  );

  crpm_ptr_file u_ptr_file (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .n_eff_i (n_eff_q),
    .upd_i   (upd),
    .tail_o  (tail),
    .ptrs_o  (ptrs),
    .avails_o(avails)
  );

  crpm_exec u_exec (
    .req_i   (req),
    .n_eff_i (n_eff_q),
    .tail_i  (tail),
    .ptrs_i  (ptrs),
    .avails_i(avails),
    .upd_o   (upd),
    .rsp_o   (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid) begin
      rsp_q <= rsp;
    end
  end

  assign done_o            = done_q;
  assign status_o          = rsp_q.status;
  assign position_o        = rsp_q.position;
  assign available_count_o = rsp_q.avail;

  `CRPM_ASSERT(a_latency, (start_i && !busy_o) |-> ##2 done_o, "request without result")
  `CRPM_ASSERT(a_no_spurious, done_o |-> $past(start_i && !busy_o, 2), "result without request")
  `CRPM_ASSERT_NEVER(a_empty_count, done_o && status_o == StEmpty && available_count_o != '0,
                     "empty status with entries available")

endmodule

/* rtl/crpm_req_reg.sv */
// Request register in front of the pointer logic
module crpm_req_reg import crpm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [1:0]       cmd_i,
  input  logic [IdW-1:0]   id_i,
  input  logic [StepW-1:0] steps_i,
  output req_t             req_o
);

  logic valid_q;
  logic [1:0] cmd_q;
  logic [IdW-1:0] id_q;
  logic [StepW-1:0] steps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      cmd_q   <= cmd_i;
      id_q    <= id_i;
      steps_q <= steps_i;
    end
  end

  assign req_o = '{valid: valid_q, cmd: cmd_q, id: id_q, steps: steps_q};

endmodule

/* rtl/crpm_ptr_file.sv */
// Tail and stage pointer registers with per-stage availability lanes
module crpm_ptr_file import crpm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [CfgW-1:0] n_eff_i,
  input  ptr_upd_t      upd_i,
  output idx_t          tail_o,
  output ptr_vec_t      ptrs_o,
  output ptr_vec_t      avails_o
);

  idx_t tail_q;
  ptr_vec_t ptrs_q;
  logic [CfgW-1:0] last_stage;
  idx_t lim0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q <= '0;
      ptrs_q <= '0;
    end else begin
      if (upd_i.tail_we) begin
        tail_q <= upd_i.tail_val;
      end
      if (upd_i.ptr_we) begin
        ptrs_q[upd_i.ptr_sel] <= upd_i.ptr_val;
      end
    end
  end

  // stage 0 follows the last active stage, or the tail when it runs alone
  assign last_stage = n_eff_i - CfgW'(1);
  assign lim0 = (n_eff_i == CfgW'(1)) ? tail_q : ptrs_q[last_stage[IdW-1:0]];

  for (genvar i = 0; i < int'(MaxStages); i++) begin : g_lane
    if (i == 0) begin : g_first
      assign avails_o[i] = lim0 - ptrs_q[i];
    end else if (i == 1) begin : g_second
      assign avails_o[i] = tail_q - ptrs_q[i];
    end else begin : g_rest
      assign avails_o[i] = ptrs_q[i-1] - ptrs_q[i];
    end
  end

  assign tail_o = tail_q;
  assign ptrs_o = ptrs_q;

endmodule

/* rtl/crpm_exec.sv */
// Command decode: reserve, peek and advance against the ring pointers
module crpm_exec import crpm_pkg::*; (
  input  req_t            req_i,
  input  logic [CfgW-1:0] n_eff_i,
  input  idx_t            tail_i,
  input  ptr_vec_t        ptrs_i,
  input  ptr_vec_t        avails_i,
  output ptr_upd_t        upd_o,
  output rsp_t            rsp_o
);

  idx_t tail_next;
  idx_t cur;
  idx_t avail;
  idx_t step_lo;
  logic bad_stage;
  logic fits;

  assign tail_next = tail_i + IdxW'(1);
  assign cur       = ptrs_i[req_i.id];
  assign avail     = avails_i[req_i.id];
  assign step_lo   = req_i.steps[IdxW-1:0];
  assign bad_stage = {{(CfgW-IdW){1'b0}}, req_i.id} >= n_eff_i;
  assign fits      = req_i.steps <= {1'b0, avail};

  always_comb begin
    upd_o = '0;
    rsp_o = '{status: StOk, position: cur, avail: avail};
    case (cmd_e'(req_i.cmd))
      CmdReserve: begin
        if (tail_next == ptrs_i[0]) begin
          rsp_o = '{status: StFull, position: '0, avail: '0};
        end else begin
          upd_o.tail_we  = req_i.valid;
          upd_o.tail_val = tail_next;
          rsp_o = '{status: StOk, position: tail_i, avail: '0};
        end
      end
      CmdAdvance: begin
        if (bad_stage) begin
          rsp_o = '{status: StBadStage, position: '0, avail: '0};
        end else if (fits) begin
          upd_o.ptr_we  = req_i.valid;
          upd_o.ptr_sel = req_i.id;
          upd_o.ptr_val = cur + step_lo;
          rsp_o = '{status: StOk, position: cur + step_lo, avail: avail - step_lo};
        end else begin
          rsp_o = '{status: StBeyond, position: cur, avail: avail};
        end
      end
      default: begin
        // peek, and the unused code behaves as peek
        if (bad_stage) begin
          rsp_o = '{status: StBadStage, position: '0, avail: '0};
        end else begin
          rsp_o = '{status: (avail == '0) ? StEmpty : StOk, position: cur, avail: avail};
        end
      end
    endcase
  end

endmodule

/* verif/crpm_checker.sv */
`timescale 1ns / 1ps
// Checker for the ring pointer manager: predicts every response and compares it with the block
module crpm_checker import crpm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CfgW-1:0]  cfg_wdata_i,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic [1:0]       cmd_i,
  input  logic [IdW-1:0]   module_id_i,
  input  logic [StepW-1:0] step_count_i,
  input  logic             done_i,
  input  logic [StatW-1:0] status_i,
  input  logic [IdxW-1:0]  position_i,
  input  logic [IdxW-1:0]  available_count_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o,
  output int unsigned      result_count_o
);

  idx_t            tail_q;
  idx_t            stage_ptr [MaxStages];
  logic [CfgW-1:0] stage_cfg;
  rsp_t            pending_rsps [$];
  int unsigned     fails;
  int unsigned     results;

  // response to one request; updates tail and stage pointers as the block does
  function automatic rsp_t ring_response(input logic [1:0] cmd, input logic [IdW-1:0] id,
                                         input logic [StepW-1:0] steps);
    int unsigned n;
    int unsigned up;
    idx_t        cur;
    idx_t        lim;
    idx_t        room;
    idx_t        nxt;
    rsp_t        r;
    n = (stage_cfg == 0) ? 1 : ((stage_cfg > MaxStages) ? MaxStages : stage_cfg);
    r.status   = StOk;
    r.position = '0;
    r.avail    = '0;
    if (cmd == CmdReserve) begin
      nxt = tail_q + 1'b1;
      if (nxt == stage_ptr[0]) begin
        r.status = StFull;
      end else begin
        r.position = tail_q;
        tail_q     = nxt;
      end
    end else if (id >= n) begin
      r.status = StBadStage;
    end else begin
      cur  = stage_ptr[id];
      up   = (id == 0) ? n - 1 : id - 1;
      lim  = (id == 1 || id == up) ? tail_q : stage_ptr[up[IdW-1:0]];
      room = lim - cur;
      r.position = cur;
      r.avail    = room;
      if (cmd == CmdAdvance) begin
        if (steps <= room) begin
          cur           = cur + steps[IdxW-1:0];
          stage_ptr[id] = cur;
          r.position    = cur;
          r.avail       = room - steps[IdxW-1:0];
        end else begin
          r.status = StBeyond;
        end
      end else if (room == 0) begin
        r.status = StEmpty;
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input rsp_t want);
    if (fails < 10) begin
      $display("%0t: %s: exp st=%0d pos=%0d avail=%0d, got st=%0d pos=%0d avail=%0d",
               $realtime, what, want.status, want.position, want.avail,
               status_i, position_i, available_count_i);
    end
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      tail_q    = '0;
      stage_cfg = 4'd1;
      foreach (stage_ptr[i]) stage_ptr[i] = '0;
      pending_rsps.delete();
      fails   = 0;
      results = 0;
      fail_count_o   <= 0;
      pending_o      <= 0;
      result_count_o <= 0;
    end else begin
      if (done_i) begin
        results++;
        if (pending_rsps.size() == 0) begin
          want = '0;
          flag_mismatch("response with no request waiting", want);
        end else begin
          want = pending_rsps.pop_front();
          if (status_i !== want.status || position_i !== want.position ||
              available_count_i !== want.avail) begin
            flag_mismatch("response mismatch", want);
          end
        end
      end
      if (start_i && !busy_i) begin
        want         = ring_response(cmd_i, module_id_i, step_count_i);
        pending_rsps = {pending_rsps, want};
      end
      if (cfg_we_i) begin
        stage_cfg = cfg_wdata_i;
      end
      fail_count_o   <= fails;
      pending_o      <= pending_rsps.size();
      result_count_o <= results;
    end
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for the ring pointer manager: clock, reset, request stimulus and verdict
module tb_top;
  import crpm_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [1:0]  CmdUnused  = 2'd3;
  localparam int unsigned NumPhases  = 10;
  localparam int unsigned PhaseCfg  [NumPhases] = '{1, 8, 4, 0, 15, 3, 9, 2, 8, 5};
  localparam int unsigned PhaseIdle [NumPhases] = '{0, 80, 0, 24, 80, 0, 24, 0, 24, 80};
  localparam int unsigned PhaseLen  [NumPhases] =
    '{80, 70, 50, 60, 60, 60, 55, 55, 55, 55};

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             cfg_we_i     = 1'b0;
  logic [CfgW-1:0]  cfg_wdata_i  = '0;
  logic             start_i      = 1'b0;
  logic [1:0]       cmd_i        = CmdReserve;
  logic [IdW-1:0]   module_id_i  = '0;
  logic [StepW-1:0] step_count_i = '0;
  logic             busy_o;
  logic             done_o;
  logic [StatW-1:0] status_o;
  logic [IdxW-1:0]  position_o;
  logic [IdxW-1:0]  available_count_o;

  int unsigned      fail_count;
  int unsigned      pending;
  int unsigned      result_count;
  int unsigned      idle_pct      = 0;
  int unsigned      reqs_sent     = 0;
  int unsigned      full_results  = 0;
  int unsigned      settings_done = 0;
  logic [CfgW-1:0]  stage_setting = 4'd1;
  idx_t             last_avail    = '0;

  chained_ring_pointer_manager u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .cmd_i             (cmd_i),
    .module_id_i       (module_id_i),
    .step_count_i      (step_count_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .position_o        (position_o),
    .available_count_o (available_count_o)
  );

  crpm_checker u_chk (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .start_i           (start_i),
    .busy_i            (busy_o),
    .cmd_i             (cmd_i),
    .module_id_i       (module_id_i),
    .step_count_i      (step_count_i),
    .done_i            (done_o),
    .status_i          (status_o),
    .position_i        (position_o),
    .available_count_i (available_count_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .result_count_o    (result_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("Timed out after %0d cycles", CycleLimit);
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (done_o) begin
      last_avail <= available_count_o;
      if (status_o == StFull) full_results <= full_results + 1;
    end
  end

  task automatic send_req(input logic [1:0] c, input logic [IdW-1:0] id,
                          input logic [StepW-1:0] st);
    int unsigned gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    cmd_i        <= c;
    module_id_i  <= id;
    step_count_i <= st;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    reqs_sent++;
  endtask

  // wait until every request has had its response
  task automatic go_quiet();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_stages(input logic [CfgW-1:0] v);
    go_quiet();
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    stage_setting = v;
    settings_done++;
  endtask

  function automatic int unsigned live_stages();
    if (stage_setting == 0) return 1;
    if (stage_setting > MaxStages) return MaxStages;
    return 32'(stage_setting);
  endfunction

  function automatic logic [StepW-1:0] pick_steps();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return StepW'($urandom_range(4));
    if (r < 70) return StepW'($urandom_range(64));
    if (r < 85) return StepW'($urandom_range(1023));
    return StepW'($urandom_range(2047, 1024));
  endfunction

  // peek a stage, then advance by all, one too many, or part of what it reported
  task automatic drain_stage(input logic [IdW-1:0] k);
    int unsigned      r;
    logic [StepW-1:0] st;
    send_req(CmdPeek, k, StepW'($urandom_range(2047)));
    go_quiet();
    r = $urandom_range(99);
    if (r < 50) st = {1'b0, last_avail};
    else if (r < 65) st = {1'b0, last_avail} + StepW'(1);
    else st = StepW'($urandom_range(32'(last_avail)));
    send_req(CmdAdvance, k, st);
  endtask

  task automatic random_item();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) begin
      send_req(CmdReserve, IdW'($urandom_range(7)), StepW'($urandom_range(2047)));
    end else if (r < 47) begin
      send_req($urandom_range(1) ? CmdPeek : CmdUnused, IdW'($urandom_range(7)),
               StepW'($urandom_range(2047)));
    end else if (r < 67) begin
      send_req(CmdAdvance, IdW'($urandom_range(7)), pick_steps());
    end else if (r < 93) begin
      drain_stage(IdW'($urandom_range(live_stages() - 1)));
    end else begin
      drain_stage(IdW'($urandom_range(7)));
    end
  endtask

  // reserve until the ring reports full, then push a few more against it
  task automatic fill_ring();
    int unsigned seen;
    int unsigned n;
    seen = full_results;
    n    = 0;
    while (full_results == seen && n < 1100) begin
      send_req(CmdReserve, IdW'($urandom_range(7)), StepW'($urandom_range(2047)));
      n++;
    end
    repeat (3) send_req(CmdReserve, IdW'($urandom_range(7)), StepW'($urandom_range(2047)));
  endtask

  initial begin
    int unsigned i;
    int unsigned w;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single stage straight after reset
    send_req(CmdPeek, 0, 0);
    send_req(CmdAdvance, 0, 0);
    send_req(CmdAdvance, 0, 1);
    send_req(CmdAdvance, 0, 11'h7FF);
    send_req(CmdPeek, 1, 0);
    send_req(CmdAdvance, 7, 5);
    send_req(CmdUnused, 0, 0);
    send_req(CmdReserve, 7, 11'h7FF);
    send_req(CmdReserve, 0, 0);
    send_req(CmdReserve, 0, 0);
    send_req(CmdPeek, 0, 0);
    send_req(CmdAdvance, 0, 3);
    send_req(CmdReserve, 0, 0);
    send_req(CmdAdvance, 0, 2);
    send_req(CmdAdvance, 0, 11'd1024);
    send_req(CmdAdvance, 0, 1);
    // full chain
    set_stages(4'd8);
    send_req(CmdReserve, 0, 0);
    send_req(CmdReserve, 0, 0);
    send_req(CmdPeek, 1, 0);
    send_req(CmdAdvance, 1, 2);
    send_req(CmdAdvance, 2, 1);
    send_req(CmdPeek, 7, 0);
    send_req(CmdPeek, 0, 0);
    send_req(CmdAdvance, 0, 0);

    foreach (PhaseCfg[p]) begin
      set_stages(CfgW'(PhaseCfg[p]));
      idle_pct = PhaseIdle[p];
      if (p == 2) fill_ring();
      for (i = 0; i < PhaseLen[p]; i++) random_item();
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    for (w = 0; w < 200 && pending != 0; w++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Sent %0d requests across %0d stage-count settings, one ring fill included;",
             reqs_sent, settings_done);
    $display("checked %0d responses, %0d of them ring full.", result_count, full_results);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      if (pending != 0) $display("%0d responses never arrived", pending);
      $display("%0d mismatches", fail_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
